[rtl/bia_pkg.sv]
// Shared types, codes and constants of the bitmap index allocator.
package bia_pkg;

	// Field widths
	localparam int IDX_W   = 10;
	localparam int SIZE_W  = 11;
	localparam int KIND_W  = 1;
	localparam int STAT_W  = 2;

	// Bitmap organization
	localparam int CAPACITY_DEF = 1024;
	localparam int WORD_BITS    = 64;
	localparam int BIT_SEL_W    = 6;
	localparam int MAX_INDICES  = 2048;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC   = 1'b0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_NO_FREE = 2'd1,
		STATUS_INVALID = 2'd2
	} resp_code_t;

	// Request sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

endpackage

[rtl/bia_if.sv]
// Valid/ready channel interfaces for allocator requests and results.
interface bia_req_if import bia_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  index;

	modport source (output valid, output kind, output index, input ready);
	modport sink   (input valid, input kind, input index, output ready);
endinterface

interface bia_rsp_if import bia_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0]  granted_index;
	logic [SIZE_W-1:0] free_left;

	modport source (output valid, output status, output granted_index, output free_left,
		input ready);
	modport sink   (input valid, input status, input granted_index, input free_left,
		output ready);
endinterface

[rtl/bitmap_index_allocator.sv]
// Bitmap index allocator: lowest-free-first identifier allocation and release.
//
// Each request takes an accept cycle and an update cycle: the accept cycle reads
// one 64-bit word of the free bitmap from a synchronous memory, and the update
// cycle modifies that word, writes it back and loads the result register. A new
// request can be taken from the cycle after the write, if no result waits unread.
// The word to read for an allocate comes from a per-word "has free" summary in
// flip-flops; a per-word valid bit makes a word that was not written since reset
// or the last size write read as all free, so a size write takes effect at once
// with no clearing pass. Writing the size register (clamped to CAPACITY) frees
// every index and sets the free count to the size; write it only while idle.
module bitmap_index_allocator import bia_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	bia_req_if.sink           req,
	bia_rsp_if.source         rsp
);

	// Only indices below the largest writable size are ever used
	localparam int EFF     = (CAPACITY < MAX_INDICES) ? CAPACITY : MAX_INDICES;
	localparam int WORDS   = (EFF + WORD_BITS - 1) / WORD_BITS;
	localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [16:0] CAP_W = 17'(CAPACITY);
	localparam logic [IDX_W-1:0] WORDS_W = IDX_W'(WORDS);

	// Clamp a size value to the capacity
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		clamp_size = (17'(v) > CAP_W) ? SIZE_W'(CAPACITY) : v;
	endfunction

	state_t state_q, state_d;

	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rdata_s1;
	logic [WORDS-1:0]     valid_q;
	logic [WORDS-1:0]     sum_q;
	logic [SIZE_W-1:0]    size_q;
	logic [SIZE_W-1:0]    count_q;

	logic [KIND_W-1:0] kind_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [AW-1:0]     addr_s1;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [IDX_W-1:0]  out_grant_q;
	logic [SIZE_W-1:0] out_free_q;

	logic accept, upd;
	logic [AW-1:0] rd_addr, alloc_addr;
	logic [IDX_W-1:0] rel_word;

	// Sequencer: accept, then update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		accept    = 1'b0;
		upd       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = !out_valid_q || rsp.ready;
				accept    = req.valid && req.ready;
				if (accept) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				upd     = 1'b1;
				state_d = ST_IDLE;
			end
		endcase
	end

	// Lowest word that still holds a free index
	always_comb begin
		alloc_addr = '0;
		for (int i = WORDS - 1; i >= 0; i--) begin
			if (sum_q[i]) alloc_addr = AW'(i);
		end
	end

	// Word holding a release index; out-of-range indices read word 0 and get rejected
	assign rel_word = req.index >> BIT_SEL_W;
	assign rd_addr  = (req.kind == KIND_RELEASE)
		? ((rel_word < WORDS_W) ? AW'(rel_word) : '0)
		: alloc_addr;

	// Bitmap memory, registered read
	logic                 mem_we;
	logic [WORD_BITS-1:0] mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) mem[addr_s1] <= mem_wdata;
		if (accept) rdata_s1 <= mem[rd_addr];
	end

	// Request held for the update cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= req.kind;
			idx_s1  <= req.index;
			addr_s1 <= rd_addr;
		end
	end

	// Modify the fetched word
	logic [WORD_BITS-1:0] word, mask;
	logic [BIT_SEL_W-1:0] low_bit, bit_sel;
	logic                 ok;
	resp_code_t           status;
	logic [SIZE_W-1:0]    count_new;
	logic [SIZE_W-1:0]    grant_full;

	always_comb begin
		low_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (word[i]) low_bit = BIT_SEL_W'(i);
		end
	end

	always_comb begin
		word       = valid_q[addr_s1] ? rdata_s1 : '1;
		bit_sel    = (kind_s1 == KIND_RELEASE) ? idx_s1[BIT_SEL_W-1:0] : low_bit;
		mask       = WORD_BITS'(1) << bit_sel;
		grant_full = (SIZE_W'(addr_s1) << BIT_SEL_W) | SIZE_W'(bit_sel);
		if (kind_s1 == KIND_ALLOC) begin
			ok        = (count_q != '0);
			status    = ok ? STATUS_OK : STATUS_NO_FREE;
			mem_wdata = word & ~mask;
			count_new = count_q - SIZE_W'(1);
		end else begin
			ok        = !((SIZE_W'(idx_s1) >= size_q) || word[bit_sel]);
			status    = ok ? STATUS_OK : STATUS_INVALID;
			mem_wdata = word | mask;
			count_new = count_q + SIZE_W'(1);
		end
		mem_we = upd && ok;
	end

	// Map bookkeeping and size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			sum_q   <= '1;
			size_q  <= clamp_size(SIZE_RESET);
			count_q <= clamp_size(SIZE_RESET);
		end else if (cfg_we) begin
			valid_q <= '0;
			sum_q   <= '1;
			size_q  <= clamp_size(cfg_wdata);
			count_q <= clamp_size(cfg_wdata);
		end else if (mem_we) begin
			valid_q[addr_s1] <= 1'b1;
			sum_q[addr_s1]   <= |mem_wdata;
			count_q          <= count_new;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (upd) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			out_status_q <= status;
			out_grant_q  <= (ok && kind_s1 == KIND_ALLOC) ? grant_full[IDX_W-1:0] : '0;
			out_free_q   <= ok ? count_new : count_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.granted_index = out_grant_q;
	assign rsp.free_left     = out_free_q;

endmodule
